// ===== rtl/btnar_pkg.sv =====
// Shared types and constants for the button edge and autorepeat unit.
`timescale 1ns / 1ps

package btnar_pkg;

    localparam int TIME_W = 48;
    localparam int CFG_W  = 24;
    localparam int LVL_W  = 8;

    localparam logic [CFG_W-1:0] DELAY_RESET    = 24'd164000;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 24'd31000;

    localparam logic REG_DELAY    = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    localparam int LVL_A      = 0;
    localparam int LVL_B      = 1;
    localparam int LVL_SELECT = 2;
    localparam int LVL_START  = 3;
    localparam int LVL_UP     = 4;
    localparam int LVL_DOWN   = 5;
    localparam int LVL_LEFT   = 6;
    localparam int LVL_RIGHT  = 7;

    typedef logic [LVL_W-1:0]  t_lvl;
    typedef logic [TIME_W-1:0] t_time;
    typedef logic [CFG_W-1:0]  t_cfg;

    typedef struct packed {
        logic upd;
        logic pressed;
    } t_dir_ctl;

endpackage

// ===== rtl/btnar_edges.sv =====
// Previous button levels and rising-edge detection for one poll.
`timescale 1ns / 1ps

module btnar_edges (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_upd,
    input  btnar_pkg::t_lvl i_lvl,
    output btnar_pkg::t_lvl o_rise
);

    btnar_pkg::t_lvl r_prev;

    assign o_rise = i_lvl & ~r_prev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (i_upd) begin
            r_prev <= i_lvl;
        end
    end

endmodule

// ===== rtl/btnar_dir_timer.sv =====
// Delayed autorepeat timer for one direction.
`timescale 1ns / 1ps

module btnar_dir_timer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btnar_pkg::t_dir_ctl i_ctl,
    input  btnar_pkg::t_time    i_now,
    input  btnar_pkg::t_cfg     i_delay,
    input  btnar_pkg::t_cfg     i_interval,
    output logic                o_fire
);

    localparam int EXT_W = btnar_pkg::TIME_W - btnar_pkg::CFG_W;

    logic             r_held;
    logic             n_held;
    btnar_pkg::t_time r_press;
    btnar_pkg::t_time n_press;
    btnar_pkg::t_time r_rep;
    btnar_pkg::t_time n_rep;
    btnar_pkg::t_time el_press;
    btnar_pkg::t_time el_rep;

    assign el_press = i_now - r_press;
    assign el_rep   = i_now - r_rep;

    always_comb begin
        n_held  = r_held;
        n_press = r_press;
        n_rep   = r_rep;
        o_fire  = 1'b0;
        if (!i_ctl.pressed) begin
            n_held = 1'b0;
        end else if (!r_held) begin
            n_held  = 1'b1;
            n_press = i_now;
            n_rep   = i_now;
            o_fire  = 1'b1;
        end else if (el_press < {{EXT_W{1'b0}}, i_delay}) begin
            o_fire = 1'b0;
        end else if (el_rep >= {{EXT_W{1'b0}}, i_interval}) begin
            n_rep  = i_now;
            o_fire = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (i_ctl.upd) begin
            r_held <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_press <= n_press;
            r_rep   <= n_rep;
        end
    end

endmodule

// ===== rtl/button_edge_and_autorepeat_unit.sv =====
// Top level of the button edge and autorepeat unit.
`timescale 1ns / 1ps

// Takes one poll of eight pad buttons with a 48-bit microsecond timestamp per
// clock cycle and returns one result per poll: rising-edge pulses, the up
// level and left/right autorepeat moves (first press, then the initial
// delay, then one move per repeat interval; when both fire, right wins).
// From request to result a poll passes an input register, then the edge logic
// and the two timestamp subtract-and-compare timers, then the result register.
// One poll per cycle is sustained while results are taken.
// Write the delay and interval registers only while no poll is in flight.
module button_edge_and_autorepeat_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_btn_a,
    input  logic        i_btn_b,
    input  logic        i_btn_select,
    input  logic        i_btn_start,
    input  logic        i_btn_up,
    input  logic        i_btn_down,
    input  logic        i_btn_left,
    input  logic        i_btn_right,
    input  logic [47:0] i_now_us,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_up_level,
    output logic        o_rotate_left,
    output logic        o_rotate_right,
    output logic        o_down_edge,
    output logic        o_hold_piece,
    output logic        o_pause_req,
    output logic        o_move_left,
    output logic        o_move_right,
    output logic        o_up_edge,
    output logic        o_left_rise,
    output logic        o_right_rise
);

    btnar_pkg::t_cfg     r_delay;
    btnar_pkg::t_cfg     r_interval;
    logic                r_in_vld;
    btnar_pkg::t_lvl     r_lvl;
    btnar_pkg::t_time    r_now;
    logic                r_out_vld;
    logic [10:0]         r_res;
    logic [10:0]         n_res;
    logic                adv;
    btnar_pkg::t_lvl     rise;
    btnar_pkg::t_dir_ctl ctl_left;
    btnar_pkg::t_dir_ctl ctl_right;
    logic                fire_left;
    logic                fire_right;

    assign adv     = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= btnar_pkg::DELAY_RESET;
            r_interval <= btnar_pkg::INTERVAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btnar_pkg::REG_DELAY:    r_delay    <= i_cfg_data;
                btnar_pkg::REG_INTERVAL: r_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // hold the request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_lvl <= {i_btn_right, i_btn_left, i_btn_down, i_btn_up,
                      i_btn_start, i_btn_select, i_btn_b, i_btn_a};
            r_now <= i_now_us;
        end
    end

    btnar_edges u_edges (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (adv),
        .i_lvl   (r_lvl),
        .o_rise  (rise)
    );

    assign ctl_left  = '{upd: adv, pressed: r_lvl[btnar_pkg::LVL_LEFT]};
    assign ctl_right = '{upd: adv, pressed: r_lvl[btnar_pkg::LVL_RIGHT]};

    btnar_dir_timer u_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_left),
        .i_now      (r_now),
        .i_delay    (r_delay),
        .i_interval (r_interval),
        .o_fire     (fire_left)
    );

    btnar_dir_timer u_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl_right),
        .i_now      (r_now),
        .i_delay    (r_delay),
        .i_interval (r_interval),
        .o_fire     (fire_right)
    );

    always_comb begin
        n_res[0]  = r_lvl[btnar_pkg::LVL_UP];
        n_res[1]  = rise[btnar_pkg::LVL_B];
        n_res[2]  = rise[btnar_pkg::LVL_A] & ~rise[btnar_pkg::LVL_B];
        n_res[3]  = rise[btnar_pkg::LVL_DOWN];
        n_res[4]  = rise[btnar_pkg::LVL_START];
        n_res[5]  = rise[btnar_pkg::LVL_SELECT];
        n_res[6]  = fire_left & ~fire_right;
        n_res[7]  = fire_right;
        n_res[8]  = rise[btnar_pkg::LVL_UP];
        n_res[9]  = rise[btnar_pkg::LVL_LEFT];
        n_res[10] = rise[btnar_pkg::LVL_RIGHT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_up_level     = r_res[0];
    assign o_rotate_left  = r_res[1];
    assign o_rotate_right = r_res[2];
    assign o_down_edge    = r_res[3];
    assign o_hold_piece   = r_res[4];
    assign o_pause_req    = r_res[5];
    assign o_move_left    = r_res[6];
    assign o_move_right   = r_res[7];
    assign o_up_edge      = r_res[8];
    assign o_left_rise    = r_res[9];
    assign o_right_rise   = r_res[10];

endmodule

// ===== rtl/btnar_checker.sv =====
// Port-level checks for the button edge and autorepeat unit.
`timescale 1ns / 1ps

module btnar_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic o_rotate_left,
    input logic o_rotate_right,
    input logic o_move_left,
    input logic o_move_right,
    input logic o_left_rise
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_rotate_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_rotate_left && o_rotate_right))
        else $error("both rotations in one result");

    a_move_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_move_left && o_move_right))
        else $error("both moves in one result");

    a_edge_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_left_rise |-> (o_move_left || o_move_right))
        else $error("left press gave no move");

endmodule

bind button_edge_and_autorepeat_unit btnar_checker u_btnar_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the button edge and autorepeat unit.
`timescale 1ns / 1ps

module testbench;

    localparam int POLLS_PER_PHASE = 80;
    localparam int NUM_PHASES      = 6;
    localparam int SCRIPT_LEN      = 25;
    localparam int STALL_LIMIT     = 2000;

    typedef enum logic {DIR_LEFT, DIR_RIGHT} t_shift_dir;

    typedef struct packed {
        logic up_level;
        logic rotate_left;
        logic rotate_right;
        logic down_edge;
        logic hold_piece;
        logic pause_req;
        logic move_left;
        logic move_right;
        logic up_edge;
        logic left_rise;
        logic right_rise;
    } t_pad_events;

    typedef struct packed {
        btnar_pkg::t_lvl  lv;
        btnar_pkg::t_time now;
        logic             typed;
        t_pad_events      res;
    } t_poll_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = btnar_pkg::REG_DELAY;
    logic [23:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_btn_a = 1'b0;
    logic        i_btn_b = 1'b0;
    logic        i_btn_select = 1'b0;
    logic        i_btn_start = 1'b0;
    logic        i_btn_up = 1'b0;
    logic        i_btn_down = 1'b0;
    logic        i_btn_left = 1'b0;
    logic        i_btn_right = 1'b0;
    logic [47:0] i_now_us = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_up_level;
    logic        o_rotate_left;
    logic        o_rotate_right;
    logic        o_down_edge;
    logic        o_hold_piece;
    logic        o_pause_req;
    logic        o_move_left;
    logic        o_move_right;
    logic        o_up_edge;
    logic        o_left_rise;
    logic        o_right_rise;

    button_edge_and_autorepeat_unit uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // columns: up_lvl rot_l rot_r down_e hold pause mv_l mv_r up_e left_r right_r
    t_poll_row script [SCRIPT_LEN] = '{
        '{8'h00, 48'd0,                1'b1, 11'b0_0_0_0_0_0_0_0_0_0_0},
        '{8'h01, 48'd10,               1'b1, 11'b0_0_1_0_0_0_0_0_0_0_0},
        '{8'h03, 48'd20,               1'b1, 11'b0_1_0_0_0_0_0_0_0_0_0},
        '{8'h00, 48'd30,               1'b1, 11'b0_0_0_0_0_0_0_0_0_0_0},
        '{8'h03, 48'd40,               1'b1, 11'b0_1_0_0_0_0_0_0_0_0_0},
        '{8'h3C, 48'd50,               1'b1, 11'b1_0_0_1_1_1_0_0_1_0_0},
        '{8'h10, 48'd60,               1'b1, 11'b1_0_0_0_0_0_0_0_0_0_0},
        '{8'h40, 48'd1000,             1'b1, 11'b0_0_0_0_0_0_1_0_0_1_0},
        '{8'h40, 48'd164999,           1'b1, 11'b0_0_0_0_0_0_0_0_0_0_0},
        '{8'h40, 48'd165000,           1'b1, 11'b0_0_0_0_0_0_1_0_0_0_0},
        '{8'h40, 48'd195999,           1'b1, 11'b0_0_0_0_0_0_0_0_0_0_0},
        '{8'h40, 48'd196000,           1'b1, 11'b0_0_0_0_0_0_1_0_0_0_0},
        '{8'hC0, 48'd196010,           1'b1, 11'b0_0_0_0_0_0_0_1_0_0_1},
        '{8'h00, 48'd196020,           1'b1, 11'b0_0_0_0_0_0_0_0_0_0_0},
        '{8'hC0, 48'd196030,           1'b1, 11'b0_0_0_0_0_0_0_1_0_1_1},
        '{8'hFF, 48'hFFFF_FFFF_FFFF,   1'b0, 11'b0},
        '{8'hC0, 48'd100,              1'b0, 11'b0},
        '{8'hC0, 48'd50,               1'b0, 11'b0},
        '{8'h00, 48'd60,               1'b1, 11'b0_0_0_0_0_0_0_0_0_0_0},
        '{8'h40, 48'hFFFF_FFFF_FF00,   1'b1, 11'b0_0_0_0_0_0_1_0_0_1_0},
        '{8'h40, 48'h0000_0002_7F00,   1'b0, 11'b0},
        '{8'h40, 48'h0000_0002_8100,   1'b0, 11'b0},
        '{8'h80, 48'h5555_5555_5555,   1'b0, 11'b0},
        '{8'h2A, 48'hAAAA_AAAA_AAAA,   1'b0, 11'b0},
        '{8'h00, 48'd0,                1'b1, 11'b0_0_0_0_0_0_0_0_0_0_0}
    };

    string event_names [11] = '{"up_level", "rotate_left", "rotate_right", "down_edge",
                                "hold_piece", "pause_req", "move_left", "move_right",
                                "up_edge", "left_rise", "right_rise"};

    btnar_pkg::t_cfg  delay_cfg = btnar_pkg::DELAY_RESET;
    btnar_pkg::t_cfg  interval_cfg = btnar_pkg::INTERVAL_RESET;
    btnar_pkg::t_lvl  last_levels = '0;
    logic             dir_held [2] = '{1'b0, 1'b0};
    btnar_pkg::t_time press_at [2] = '{48'd0, 48'd0};
    btnar_pkg::t_time repeat_at [2] = '{48'd0, 48'd0};
    t_shift_dir       last_shift = DIR_LEFT;

    t_pad_events due_events [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    logic        calm = 1'b0;

    function automatic logic shift_timer_step(t_shift_dir d, logic pressed,
                                              btnar_pkg::t_time now);
        btnar_pkg::t_time since;
        if (!pressed) begin
            dir_held[d] = 1'b0;
            press_at[d] = '0;
            repeat_at[d] = '0;
            return 1'b0;
        end
        if (!dir_held[d]) begin
            dir_held[d] = 1'b1;
            press_at[d] = now;
            repeat_at[d] = now;
            last_shift = d;
            return 1'b1;
        end
        since = now - press_at[d];
        if (since < btnar_pkg::TIME_W'(delay_cfg))
            return 1'b0;
        since = now - repeat_at[d];
        if (since >= btnar_pkg::TIME_W'(interval_cfg)) begin
            repeat_at[d] = now;
            last_shift = d;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_pad_events predict_pad_events(btnar_pkg::t_lvl lv,
                                                       btnar_pkg::t_time now);
        t_pad_events     r;
        btnar_pkg::t_lvl rise;
        logic            ml;
        logic            mr;
        rise = lv & ~last_levels;
        last_levels = lv;
        r = '0;
        r.up_level     = lv[btnar_pkg::LVL_UP];
        r.rotate_left  = rise[btnar_pkg::LVL_B];
        r.rotate_right = rise[btnar_pkg::LVL_A] & ~rise[btnar_pkg::LVL_B];
        r.down_edge    = rise[btnar_pkg::LVL_DOWN];
        r.hold_piece   = rise[btnar_pkg::LVL_START];
        r.pause_req    = rise[btnar_pkg::LVL_SELECT];
        r.up_edge      = rise[btnar_pkg::LVL_UP];
        r.left_rise    = rise[btnar_pkg::LVL_LEFT];
        r.right_rise   = rise[btnar_pkg::LVL_RIGHT];
        ml = shift_timer_step(DIR_LEFT, lv[btnar_pkg::LVL_LEFT], now);
        mr = shift_timer_step(DIR_RIGHT, lv[btnar_pkg::LVL_RIGHT], now);
        if (ml && mr) begin
            if (last_shift == DIR_RIGHT)
                ml = 1'b0;
            else
                mr = 1'b0;
        end
        r.move_left  = ml;
        r.move_right = mr;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic btnar_pkg::t_time pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return btnar_pkg::t_time'($urandom_range(0, interval_cfg));
        if (r < 50)
            return btnar_pkg::t_time'(longint'(interval_cfg) + $urandom_range(0, 2) - 1);
        if (r < 65)
            return btnar_pkg::t_time'(longint'(delay_cfg) + $urandom_range(0, 2) - 1);
        if (r < 80)
            return btnar_pkg::t_time'($urandom_range(0, delay_cfg));
        if (r < 90)
            return '0;
        return btnar_pkg::t_time'($urandom);
    endfunction

    task automatic report_mismatch(string msg);
        $display("poll result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic send_poll(btnar_pkg::t_lvl lv, btnar_pkg::t_time now, logic typed,
                             t_pad_events typed_res);
        t_pad_events guess;
        i_valid      <= 1'b1;
        i_btn_a      <= lv[btnar_pkg::LVL_A];
        i_btn_b      <= lv[btnar_pkg::LVL_B];
        i_btn_select <= lv[btnar_pkg::LVL_SELECT];
        i_btn_start  <= lv[btnar_pkg::LVL_START];
        i_btn_up     <= lv[btnar_pkg::LVL_UP];
        i_btn_down   <= lv[btnar_pkg::LVL_DOWN];
        i_btn_left   <= lv[btnar_pkg::LVL_LEFT];
        i_btn_right  <= lv[btnar_pkg::LVL_RIGHT];
        i_now_us     <= now;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        guess = predict_pad_events(lv, now);
        due_events.push_back(typed ? typed_res : guess);
    endtask

    task automatic idle_after_poll();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (due_events.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_timing(btnar_pkg::t_cfg delay, btnar_pkg::t_cfg interval);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= btnar_pkg::REG_DELAY;
        i_cfg_data <= delay;
        @(posedge i_clk);
        delay_cfg = delay;
        i_cfg_idx  <= btnar_pkg::REG_INTERVAL;
        i_cfg_data <= interval;
        @(posedge i_clk);
        interval_cfg = interval;
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_pad_events got;
        t_pad_events want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_up_level, o_rotate_left, o_rotate_right, o_down_edge, o_hold_piece,
                   o_pause_req, o_move_left, o_move_right, o_up_edge, o_left_rise,
                   o_right_rise};
            if (due_events.size() == 0) begin
                report_mismatch("arrived with nothing outstanding");
            end else begin
                want = due_events.pop_front();
                for (int i = 0; i < 11; i++)
                    if (got[10-i] !== want[10-i])
                        report_mismatch($sformatf("%s is %0b, expected %0b",
                                                  event_names[i], got[10-i], want[10-i]));
            end
            results_seen++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        btnar_pkg::t_lvl  lv;
        btnar_pkg::t_time stamp;
        btnar_pkg::t_lvl  flips;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            send_poll(script[k].lv, script[k].now, script[k].typed, script[k].res);
            idle_after_poll();
        end

        lv = '0;
        stamp = btnar_pkg::t_time'({$urandom, $urandom});
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                drain_results();
                case (p)
                    1: set_timing('0, '0);
                    2: set_timing('1, '1);
                    3: set_timing(btnar_pkg::t_cfg'($urandom_range(1, 300)),
                                  btnar_pkg::t_cfg'($urandom_range(1, 60)));
                    4: set_timing(btnar_pkg::t_cfg'($urandom), btnar_pkg::t_cfg'($urandom));
                    default: set_timing('0, '1);
                endcase
            end
            for (int n = 0; n < POLLS_PER_PHASE; n++) begin
                calm = (n >= 50 && n < 70);
                if ($urandom_range(0, 99) < 85) begin
                    flips = '0;
                    for (int b = 0; b < btnar_pkg::LVL_W; b++)
                        flips[b] = ($urandom_range(0, 7) == 0);
                    lv = lv ^ flips;
                    stamp = stamp + pick_step();
                end else begin
                    lv = btnar_pkg::t_lvl'($urandom);
                    if ($urandom_range(0, 1) == 0)
                        stamp = btnar_pkg::t_time'({$urandom, $urandom});
                    else
                        stamp = stamp - btnar_pkg::t_time'($urandom_range(1, 1000));
                end
                send_poll(lv, stamp, 1'b0, '0);
                idle_after_poll();
            end
        end
        calm = 1'b0;

        drain_results();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
